[hw/rtl/vns_pkg.sv]
package vns_pkg;

  localparam int COORD_BITS     = 12;
  localparam int SPEED_BITS     = 14;
  localparam int VEL_BITS       = 16;
  localparam int NORM_SHIFT_DEF = 8;
  localparam int PADDR_W        = 3;
  localparam int PDATA_W        = 32;

  localparam logic signed [COORD_BITS-1:0] ORIGIN_Y_RST   = 12'sd200;
  localparam logic        [SPEED_BITS-1:0] BASE_SPEED_RST = 14'd64;

  typedef enum logic [0:0] {
    REG_ORIGIN_Y   = 1'b0,
    REG_BASE_SPEED = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQR,
    ST_ROOT,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } vns_state_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] origin_x;
    logic signed [COORD_BITS-1:0] dest_x;
    logic signed [COORD_BITS-1:0] dest_y;
    logic                         fast;
  } in_item_t;

  typedef struct packed {
    logic signed [VEL_BITS-1:0] vel_x;
    logic signed [VEL_BITS-1:0] vel_y;
    logic                       ok;
  } out_item_t;

  typedef struct packed {
    logic idle;
    logic done;
  } core_status_t;

endpackage

[hw/rtl/vns_core.sv]
module vns_core import vns_pkg::*; #(
  parameter int NORM_SHIFT = NORM_SHIFT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  in_item_t                     item_i,
  input  logic signed [COORD_BITS-1:0] origin_y_i,
  input  logic        [SPEED_BITS-1:0] base_speed_i,
  input  logic                         ack_i,
  output core_status_t                 status_o,
  output out_item_t                    result_o
);

  localparam int MAG_W   = COORD_BITS;
  localparam int DSQ_W   = 2 * COORD_BITS + 1;
  localparam int ROOT_IT = (DSQ_W + 1) / 2;
  localparam int RW      = ROOT_IT;
  localparam int DIV_W   = COORD_BITS + NORM_SHIFT;
  localparam int Q_W     = NORM_SHIFT + 1;
  localparam int SPD_W   = SPEED_BITS + 1;
  localparam int P_W     = Q_W + SPD_W;
  localparam int CNT_W   = $clog2(DIV_W + 1);
  localparam logic [DSQ_W-1:0] BIT_INIT = DSQ_W'(1) << (2 * (ROOT_IT - 1));
  localparam logic [DIV_W-1:0] Q_MAX    = DIV_W'(1) << NORM_SHIFT;

  vns_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q;
  logic             cnt_zero;

  logic             sx_q, sy_q, zero_q;
  logic [MAG_W-1:0] ax_q, ay_q, mx_q, my_q;
  logic [DSQ_W-1:0] cx_q, cy_q, acc_q, root_q, bit_q;
  logic [DIV_W-1:0] dvx_q, dvy_q;
  logic [RW-1:0]    rx_q, ry_q;
  logic [P_W-1:0]   spd_q, px_q, py_q;

  logic [COORD_BITS:0]  dx, dy, dx_abs, dy_abs;
  logic                 zero;
  logic [SPD_W-1:0]     speed;
  logic [DSQ_W:0]       trial;
  logic                 root_ge;
  logic [RW:0]          dist_e, tx, ty;
  logic                 gex, gey;
  logic [P_W:0]         pxe, pye;
  logic signed [P_W:0]  vx_s, vy_s, vx_sh, vy_sh;

  assign dx = {item_i.dest_x[COORD_BITS-1], item_i.dest_x}
            - {item_i.origin_x[COORD_BITS-1], item_i.origin_x};
  assign dy = {item_i.dest_y[COORD_BITS-1], item_i.dest_y}
            - {origin_y_i[COORD_BITS-1], origin_y_i};
  assign dx_abs = dx[COORD_BITS] ? -dx : dx;
  assign dy_abs = dy[COORD_BITS] ? -dy : dy;
  assign zero   = (dx == '0) && (dy == '0);
  assign speed  = item_i.fast ? {base_speed_i, 1'b0} : {1'b0, base_speed_i};

  assign cnt_zero = (cnt_q == '0);
  assign trial    = {1'b0, root_q} + {1'b0, bit_q};
  assign root_ge  = ({1'b0, acc_q} >= trial);
  assign dist_e   = {1'b0, root_q[RW-1:0]};
  assign tx       = {rx_q, dvx_q[DIV_W-1]};
  assign ty       = {ry_q, dvy_q[DIV_W-1]};
  assign gex      = (tx >= dist_e);
  assign gey      = (ty >= dist_e);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start_i) state_d = zero ? ST_DONE : ST_SQR;
      ST_SQR:  if (cnt_zero) state_d = ST_ROOT;
      ST_ROOT: if (cnt_zero) state_d = ST_DIV;
      ST_DIV:  if (cnt_zero) state_d = ST_MUL;
      ST_MUL:  if (cnt_zero) state_d = ST_DONE;
      ST_DONE: if (ack_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    status_o.idle = (state_q == ST_IDLE);
    status_o.done = (state_q == ST_DONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: if (start_i) cnt_q <= CNT_W'(MAG_W - 1);
        ST_SQR:  cnt_q <= cnt_zero ? CNT_W'(ROOT_IT - 1) : cnt_q - 1'b1;
        ST_ROOT: cnt_q <= cnt_zero ? CNT_W'(DIV_W - 1) : cnt_q - 1'b1;
        ST_DIV:  cnt_q <= cnt_zero ? CNT_W'(Q_W - 1) : cnt_q - 1'b1;
        ST_MUL:  if (!cnt_zero) cnt_q <= cnt_q - 1'b1;
        ST_DONE: cnt_q <= cnt_q;
        default: cnt_q <= '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          sx_q   <= dx[COORD_BITS];
          sy_q   <= dy[COORD_BITS];
          zero_q <= zero;
          ax_q   <= dx_abs[MAG_W-1:0];
          ay_q   <= dy_abs[MAG_W-1:0];
          mx_q   <= dx_abs[MAG_W-1:0];
          my_q   <= dy_abs[MAG_W-1:0];
          cx_q   <= DSQ_W'(dx_abs[MAG_W-1:0]);
          cy_q   <= DSQ_W'(dy_abs[MAG_W-1:0]);
          acc_q  <= '0;
          spd_q  <= P_W'(speed);
        end
      end
      ST_SQR: begin
        acc_q <= acc_q + (mx_q[0] ? cx_q : '0) + (my_q[0] ? cy_q : '0);
        mx_q  <= mx_q >> 1;
        my_q  <= my_q >> 1;
        cx_q  <= cx_q << 1;
        cy_q  <= cy_q << 1;
        if (cnt_zero) begin
          root_q <= '0;
          bit_q  <= BIT_INIT;
        end
      end
      ST_ROOT: begin
        if (root_ge) begin
          acc_q  <= acc_q - trial[DSQ_W-1:0];
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
        if (cnt_zero) begin
          dvx_q <= {ax_q, {NORM_SHIFT{1'b0}}};
          dvy_q <= {ay_q, {NORM_SHIFT{1'b0}}};
          rx_q  <= '0;
          ry_q  <= '0;
        end
      end
      ST_DIV: begin
        rx_q  <= gex ? RW'(tx - dist_e) : tx[RW-1:0];
        ry_q  <= gey ? RW'(ty - dist_e) : ty[RW-1:0];
        dvx_q <= {dvx_q[DIV_W-2:0], gex};
        dvy_q <= {dvy_q[DIV_W-2:0], gey};
        if (cnt_zero) begin
          px_q <= '0;
          py_q <= '0;
        end
      end
      ST_MUL: begin
        px_q  <= px_q + (dvx_q[0] ? spd_q : '0);
        py_q  <= py_q + (dvy_q[0] ? spd_q : '0);
        dvx_q <= dvx_q >> 1;
        dvy_q <= dvy_q >> 1;
        spd_q <= spd_q << 1;
      end
      ST_DONE: begin
        acc_q <= acc_q;
      end
      default: begin
        acc_q <= acc_q;
      end
    endcase
  end

  assign pxe   = {1'b0, px_q};
  assign pye   = {1'b0, py_q};
  assign vx_s  = sx_q ? signed'(-pxe) : signed'(pxe);
  assign vy_s  = sy_q ? signed'(-pye) : signed'(pye);
  assign vx_sh = vx_s >>> NORM_SHIFT;
  assign vy_sh = vy_s >>> NORM_SHIFT;

  always_comb begin
    result_o.vel_x = zero_q ? '0 : vx_sh[VEL_BITS-1:0];
    result_o.vel_y = zero_q ? '0 : vy_sh[VEL_BITS-1:0];
    result_o.ok    = !zero_q;
  end

`ifndef NO_ASSERTIONS
  a_quot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL && $past(state_q) == ST_DIV)
      |-> (dvx_q <= Q_MAX && dvy_q <= Q_MAX))
    else $error("normalized component exceeds unit magnitude");

  a_root_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> ((root_q >> RW) == '0))
    else $error("distance wider than divisor");

  a_phase_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != $past(state_q) && $past(state_q) != ST_IDLE
      && $past(state_q) != ST_DONE) |-> ($past(cnt_q) == '0))
    else $error("phase left before its count ran out");
`endif

endmodule

[hw/rtl/vector_normalize_scale.sv]
// channel  | handshake                      | payload
// input    | in_valid_i / in_stall_o        | in_item_i  (in_item_t)
// output   | out_valid_o / out_stall_i      | out_item_o (out_item_t)
// config   | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
// One item at a time: accept, serial squaring, (2*COORD_BITS+2)/2 square
// root steps, COORD_BITS+NORM_SHIFT division steps, NORM_SHIFT+1 multiply
// steps, then the move to the output register. A target equal to the origin
// skips straight from accept to the output register.
// The next item is taken once the result has moved to the output register.
// Reset clears control state and loads origin_y = 200, base_speed = 64.
module vector_normalize_scale import vns_pkg::*; #(
  parameter int NORM_SHIFT = NORM_SHIFT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_item_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic signed [COORD_BITS-1:0] origin_y_q;
  logic        [SPEED_BITS-1:0] base_speed_q;
  reg_idx_e                     reg_idx;
  logic                         cfg_we;

  core_status_t status;
  out_item_t    result;
  logic         start, ack;
  logic         out_valid_q, out_valid_d;
  out_item_t    out_item_q;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_y_q   <= ORIGIN_Y_RST;
      base_speed_q <= BASE_SPEED_RST;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_ORIGIN_Y:   origin_y_q   <= pwdata[COORD_BITS-1:0];
        REG_BASE_SPEED: base_speed_q <= pwdata[SPEED_BITS-1:0];
        default:        origin_y_q   <= origin_y_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ORIGIN_Y:   prdata = PDATA_W'(unsigned'(origin_y_q));
      REG_BASE_SPEED: prdata = PDATA_W'(base_speed_q);
      default:        prdata = '0;
    endcase
  end

  assign in_stall_o = !status.idle;
  assign start      = in_valid_i && status.idle;
  assign ack        = status.done && (!out_valid_q || !out_stall_i);

  vns_core #(
    .NORM_SHIFT(NORM_SHIFT)
  ) u_core (
    .clk_i,
    .rst_ni,
    .start_i      (start),
    .item_i       (in_item_i),
    .origin_y_i   (origin_y_q),
    .base_speed_i (base_speed_q),
    .ack_i        (ack),
    .status_o     (status),
    .result_o     (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (ack) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ack) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
